>>> design/dvrd_pkg.sv
// shared types and constants of the delta varint record decoder
package dvrd_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_RECORD   = 2'd0,
    ST_OVERLONG = 2'd1,
    ST_BADINDEX = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  // body parse phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_PARSE = 4'b0010,
    PH_DONE  = 4'b0100,
    PH_ERROR = 4'b1000
  } phase_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENTRY_COUNT   = 2'd0,
    CFG_INDEX_LIMIT   = 2'd1,
    CFG_VARINT_FORMAT = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  localparam int unsigned CountW    = 17;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // live configuration seen by the parser
  typedef struct packed {
    logic [CountW-1:0] eff_count;
    logic [31:0]       index_limit;
    logic              varint_format;
  } cfg_t;

  // one result request
  typedef struct packed {
    status_e     status;
    logic [63:0] address;
    logic [31:0] replacement_index;
    logic [31:0] record_flags;
    logic        final_entry;
    logic        run_end;
  } result_t;

  // byte held in the input register
  typedef struct packed {
    logic [7:0] body_byte;
    logic       first_byte;
    logic       last_byte;
  } byte_t;

  // results produced by one byte
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } res_pair_t;

endpackage

>>> design/delta_varint_record_decoder.sv
// top level of the delta varint record decoder
//
// parses a decompressed patch-plan body, one byte per input request, into
// records (address, replacement index, flags) or error results
// input channel: in_valid_i / in_ready_o with body_byte_i, first_byte_i and
//   last_byte_i; a byte with first_byte_i set restarts the parse
// output channel: out_valid_o / out_ready_i with one result per request;
//   run_end_o marks the last result caused by a byte (at most two)
// config channel: cfg_valid_i / cfg_ready_o, always ready; index 0 entry
//   count, 1 index limit, 2 varint format; index 3 is ignored
// path: a byte accepted into the input register is decoded once the queue has
//   room for two results, and its results are registered in the result queue
// throughput: one byte per cycle while the queue has room, set by the decode
//   between the input register and the result queue; a byte with two results
//   offers them on the output one after the other
// stall: the four-entry result queue keeps taking bytes while it has room
//   for two more results, then in_ready_o drops until the receiver drains it
// reset: parse phase idle, queue empty, registers at entry count 1,
//   index limit 256, varint mode
module delta_varint_record_decoder #(
  parameter int unsigned MAX_RECORDS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // body byte requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  body_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  // result requests
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] address_o,
  output logic [31:0] replacement_index_o,
  output logic [31:0] record_flags_o,
  output logic        final_entry_o,
  output logic        run_end_o,
  // register write requests
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import dvrd_pkg::*;

  // config registers; the entry count is stored already clamped
  logic [CountW-1:0] eff_count_q;
  logic [31:0]       index_limit_q;
  logic              varint_format_q;
  logic [CountW-1:0] count_clamped;
  logic              cfg_write;
  cfg_t              cfg;

  // input register
  logic              in_vld_q;
  byte_t             in_q;
  logic              process;
  logic              space;
  res_pair_t         res_pair;
  result_t           head;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // of the low data bits, zero counts as one, anything above the record limit as the limit
  always_comb begin
    count_clamped = cfg_data_i[CountW-1:0];
    if (count_clamped == '0) begin
      count_clamped = CountW'(1);
    end else if (32'(count_clamped) > 32'(MAX_RECORDS)) begin
      count_clamped = CountW'(MAX_RECORDS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_count_q     <= CountW'(1);
      index_limit_q   <= 32'd256;
      varint_format_q <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENTRY_COUNT:   eff_count_q     <= count_clamped;
        CFG_INDEX_LIMIT:   index_limit_q   <= cfg_data_i;
        CFG_VARINT_FORMAT: varint_format_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.eff_count     = eff_count_q;
  assign cfg.index_limit   = index_limit_q;
  assign cfg.varint_format = varint_format_q;

  // decode the held byte whenever the queue can absorb two results
  assign process    = in_vld_q && space;
  assign in_ready_o = !in_vld_q || space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.body_byte  <= body_byte_i;
      in_q.first_byte <= first_byte_i;
      in_q.last_byte  <= last_byte_i;
    end
  end

  dvrd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .process_i (process),
    .byte_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res_pair)
  );

  dvrd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res_pair),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (head)
  );

  assign status_o            = head.status;
  assign address_o           = head.address;
  assign replacement_index_o = head.replacement_index;
  assign record_flags_o      = head.record_flags;
  assign final_entry_o       = head.final_entry;
  assign run_end_o           = head.run_end;

endmodule

>>> design/dvrd_parser.sv
// parse state and per-byte record decode logic
module dvrd_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               process_i,
  input  dvrd_pkg::byte_t    byte_i,
  input  dvrd_pkg::cfg_t     cfg_i,
  output dvrd_pkg::res_pair_t res_o
);
  import dvrd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] rd_q, rd_d;
  logic [3:0]        fp_q, fp_d;
  logic [3:0]        vbc_q, vbc_d;
  logic [63:0]       acc_q, acc_d;
  logic [63:0]       ra_q, ra_d;
  logic [63:0]       held_q, held_d;

  logic [3:0]        cnt;
  logic [3:0]        cnt_inc;
  logic [6:0]        shamt;
  logic [2:0]        sh;
  logic [63:0]       val;
  logic              finish;
  logic              fin;
  result_t           rec;
  result_t           err;

  always_comb begin
    phase_d = byte_i.first_byte ? PH_PARSE : phase_q;
    rd_d    = byte_i.first_byte ? '0 : rd_q;
    fp_d    = byte_i.first_byte ? '0 : fp_q;
    vbc_d   = byte_i.first_byte ? '0 : vbc_q;
    acc_d   = byte_i.first_byte ? '0 : acc_q;
    ra_d    = byte_i.first_byte ? '0 : ra_q;
    held_d  = byte_i.first_byte ? '0 : held_q;
    res_o   = '0;
    cnt     = '0;
    cnt_inc = '0;
    shamt   = '0;
    sh      = '0;
    val     = '0;
    finish  = 1'b0;
    fin     = 1'b0;
    rec     = '0;
    err     = '0;
    if (process_i && phase_d == PH_PARSE) begin
      if (cfg_i.varint_format) begin
        cnt     = (vbc_d > 4'd9) ? 4'd9 : vbc_d;
        shamt   = 7'({3'b000, cnt} * 7'd7);
        acc_d   = acc_d | (64'(byte_i.body_byte[6:0]) << shamt);
        cnt_inc = cnt + 4'd1;
        if (byte_i.body_byte[7]) begin
          if (cnt_inc >= 4'd10) begin
            err.status  = ST_OVERLONG;
            res_o.res0  = err;
            res_o.push0 = 1'b1;
            phase_d     = PH_ERROR;
          end
          vbc_d = cnt_inc;
        end else begin
          val   = acc_d;
          acc_d = '0;
          vbc_d = '0;
          if (fp_d == 4'd0) begin
            ra_d = ra_d + val;
            fp_d = 4'd1;
          end else if (fp_d == 4'd1) begin
            held_d = val;
            fp_d   = 4'd2;
          end else begin
            // positions above two count as the flags field
            fp_d   = 4'd0;
            finish = 1'b1;
          end
        end
      end else begin
        // byte lane within the current 8 or 4 byte field
        sh    = fp_d[3] ? {1'b0, fp_d[1:0]} : fp_d[2:0];
        acc_d = acc_d | (64'(byte_i.body_byte) << {sh, 3'b000});
        val   = acc_d;
        case (fp_d)
          4'd7: begin
            ra_d  = acc_d;
            acc_d = '0;
          end
          4'd11: begin
            held_d = acc_d;
            acc_d  = '0;
          end
          4'd15: begin
            acc_d  = '0;
            finish = 1'b1;
          end
          default: ;
        endcase
        fp_d = fp_d + 4'd1;
      end

      if (finish) begin
        if (held_d[63:32] != 32'd0 || held_d[31:0] >= cfg_i.index_limit) begin
          err.status = ST_BADINDEX;
          res_o.res0 = err;
          phase_d    = PH_ERROR;
        end else begin
          rd_d                  = rd_d + CountW'(1);
          fin                   = rd_d >= cfg_i.eff_count;
          rec.status            = ST_RECORD;
          rec.address           = ra_d;
          rec.replacement_index = held_d[31:0];
          rec.record_flags      = val[31:0];
          rec.final_entry       = fin;
          res_o.res0            = rec;
          if (fin) begin
            phase_d = PH_DONE;
          end
        end
        res_o.push0 = 1'b1;
      end

      if (byte_i.last_byte && phase_d == PH_PARSE) begin
        err        = '0;
        err.status = ST_TRUNC;
        if (res_o.push0) begin
          res_o.res1  = err;
          res_o.push1 = 1'b1;
        end else begin
          res_o.res0  = err;
          res_o.push0 = 1'b1;
        end
        phase_d = PH_ERROR;
      end

      if (res_o.push1) begin
        res_o.res1.run_end = 1'b1;
      end else if (res_o.push0) begin
        res_o.res0.run_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rd_q    <= '0;
      fp_q    <= '0;
      vbc_q   <= '0;
      acc_q   <= '0;
      ra_q    <= '0;
      held_q  <= '0;
    end else if (process_i) begin
      phase_q <= phase_d;
      rd_q    <= rd_d;
      fp_q    <= fp_d;
      vbc_q   <= vbc_d;
      acc_q   <= acc_d;
      ra_q    <= ra_d;
      held_q  <= held_d;
    end
  end

endmodule

>>> design/dvrd_out_fifo.sv
// result queue, up to two pushes and one pop per cycle
module dvrd_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dvrd_pkg::res_pair_t res_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output dvrd_pkg::result_t   res_o
);
  import dvrd_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;
  logic [FifoPtrW-1:0] wr_ptr_nxt;

  assign valid_o    = cnt_q != '0;
  assign res_o      = mem_q[rd_ptr_q];
  assign pop        = valid_o && ready_i;
  // room for a two-result byte
  assign space_o    = cnt_q <= FifoCntW'(FifoDepth - 2);
  assign wr_ptr_nxt = wr_ptr_q + FifoPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (res_i.push1) begin
      wr_ptr_d = wr_ptr_q + FifoPtrW'(2);
    end else if (res_i.push0) begin
      wr_ptr_d = wr_ptr_nxt;
    end
    rd_ptr_d = pop ? rd_ptr_q + FifoPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + FifoCntW'(res_i.push0) + FifoCntW'(res_i.push1) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (res_i.push0) begin
      mem_q[wr_ptr_q] <= res_i.res0;
    end
    if (res_i.push1) begin
      mem_q[wr_ptr_nxt] <= res_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
